// ===== design/spj_pkg.sv =====
// ----------------------------------------------------------------------------
// spj_pkg: shared widths, types and constants of the segment pair junction
// Coordinate and tolerance formats used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package spj_pkg;

    // fixed-point format of the pixel coordinates
    localparam int COORD_FRAC_BITS = 4;
    localparam int COORD_W         = 20;
    localparam int TOL_W           = 14;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [TOL_W-1:0]   tol_t;

    // tolerance after reset is one pixel
    localparam tol_t   TOL_RESET = tol_t'(1) << COORD_FRAC_BITS;
    localparam coord_t COORD_MAX = coord_t'(20'sh7FFFF);
    localparam coord_t COORD_MIN = coord_t'(20'sh80000);

endpackage

// ===== design/spj_if.sv =====
// ----------------------------------------------------------------------------
// spj channel interfaces
// Valid/ready channels for segment pairs, junction results and the tolerance.
// ----------------------------------------------------------------------------

// segment pair request channel
interface spj_in_if;
    logic            valid;
    logic            ready;
    spj_pkg::coord_t first_start_x;
    spj_pkg::coord_t first_start_y;
    spj_pkg::coord_t first_end_x;
    spj_pkg::coord_t first_end_y;
    spj_pkg::coord_t second_start_x;
    spj_pkg::coord_t second_start_y;
    spj_pkg::coord_t second_end_x;
    spj_pkg::coord_t second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

// junction result channel
interface spj_out_if;
    logic            valid;
    logic            ready;
    logic            hit;
    spj_pkg::coord_t junction_x;
    spj_pkg::coord_t junction_y;
    logic            by_endpoint;

    modport source (output valid, hit, junction_x, junction_y, by_endpoint, input ready);
    modport sink   (input valid, hit, junction_x, junction_y, by_endpoint, output ready);
endinterface

// tolerance write channel
interface spj_cfg_if;
    logic          valid;
    logic          ready;
    spj_pkg::tol_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/segment_pair_junction_unit.sv =====
// ----------------------------------------------------------------------------
// segment_pair_junction_unit: junction of two segments within a tolerance
// Endpoint proximity first, then line crossing with an overshoot check.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : one request per segment pair (both segments' start and end).
//   out_ch : one result per request, in request order: hit, junction point
//            and whether the junction came from the endpoint test.
//   cfg    : writes the 14-bit tolerance; always ready, write only while idle.
// Throughput is one request per cycle while the receiver takes results.
// From acceptance to a valid result a request passes 7 stages of differences,
// products and sign handling, 22 stages of a pipelined restoring divider (one
// quotient bit each, the two 21-step length square roots running alongside),
// and 4 stages of length rounding, overshoot products, sum and the final select.
// The whole pipeline advances whenever the output register is empty or taken,
// so a stalled receiver holds every stage in place and in_ch.ready drops;
// nothing is lost or repeated.
// Reset clears all stage valid bits and loads the tolerance with one pixel.
// ----------------------------------------------------------------------------
module segment_pair_junction_unit (
    input  logic        clk,
    input  logic        rst_n,
    spj_in_if.sink      in_ch,
    spj_out_if.source   out_ch,
    spj_cfg_if.sink     cfg
);

    localparam int COORD_W   = spj_pkg::COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int TOL_W     = spj_pkg::TOL_W;
    localparam int LEN_W     = DIFF_W;
    localparam int SPLIT     = DIFF_W;
    localparam int NUM_W     = 64;
    localparam int QUO_W     = DIFF_W + 1;
    localparam int REM_W     = 66;
    localparam int SREM_W    = PROD_W + 2;
    localparam int RHS_W     = TOL_W + PROD_W;
    localparam int SRT_STEPS = LEN_W;
    localparam int NB        = QUO_W;
    localparam int NPAIR     = 4;
    localparam int NST       = 7 + NB + 4;

    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic        [PROD_W-1:0]  usq_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic        [REM_W-1:0]   rem_t;
    typedef logic        [QUO_W-1:0]   quo_t;
    typedef logic        [SREM_W-1:0]  srem_t;
    typedef logic        [LEN_W-1:0]   len_t;
    typedef logic        [RHS_W-1:0]   rhs_t;

    typedef struct packed {
        spj_pkg::coord_t                     p1x, p1y;
        diff_t                               d1x, d1y, d2x, d2y, rx, ry;
        logic [NPAIR-1:0][DIFF_W-1:0]        ep_dx, ep_dy;
        logic [NPAIR-1:0][COORD_W-1:0]       ep_mx, ep_my;
    } a1_t;

    typedef struct packed {
        spj_pkg::coord_t                     p1x, p1y;
        diff_t                               d1x, d1y;
        logic [NPAIR-1:0][PROD_W-1:0]        ep_sqx, ep_sqy;
        logic [2*TOL_W-1:0]                  tt;
        prod_t                               den_a, den_b, tn_a, tn_b, un_a, un_b;
        usq_t                                l1x, l1y, l2x, l2y;
        logic [NPAIR-1:0][COORD_W-1:0]       ep_mx, ep_my;
    } a2_t;

    typedef struct packed {
        logic                                ep_hit;
        spj_pkg::coord_t                     ep_x, ep_y, p1x, p1y;
        diff_t                               d1x, d1y;
        cross_t                              den, tn, un;
        usq_t                                len1sq, len2sq;
    } a3_t;

    typedef struct packed {
        logic                                ep_hit, den_zero;
        spj_pkg::coord_t                     ep_x, ep_y, p1x, p1y;
        diff_t                               d1x, d1y;
        usq_t                                den;
        cross_t                              tn, un;
        usq_t                                len1sq, len2sq;
    } a4_t;

    typedef struct packed {
        logic                                ep_hit, den_zero;
        spj_pkg::coord_t                     ep_x, ep_y, p1x, p1y;
        usq_t                                den, ot, ou;
        cross_t                              pxh, pxl, pyh, pyl;
        rhs_t                                rhs;
        usq_t                                len1sq, len2sq;
    } a5_t;

    typedef struct packed {
        logic                                ep_hit, den_zero;
        spj_pkg::coord_t                     ep_x, ep_y, p1x, p1y;
        usq_t                                den, ot, ou;
        num_t                                numx, numy;
        rhs_t                                rhs;
        usq_t                                len1sq, len2sq;
    } a6_t;

    typedef struct packed {
        logic                                ep_hit, den_zero;
        spj_pkg::coord_t                     ep_x, ep_y, p1x, p1y;
        usq_t                                ot, ou;
        rhs_t                                rhs;
        logic [PROD_W:0]                     dd;
        logic                                negx, negy, ovfx, ovfy;
        rem_t                                remx, remy;
        quo_t                                qx, qy;
        srem_t                               srem1, srem2;
        len_t                                root1, root2;
    } b_t;

    typedef struct packed {
        logic                                ep_hit, den_zero;
        spj_pkg::coord_t                     ep_x, ep_y, jx, jy;
        usq_t                                ot, ou;
        len_t                                len1, len2;
        rhs_t                                rhs;
    } c1_t;

    typedef struct packed {
        logic                                ep_hit, den_zero;
        spj_pkg::coord_t                     ep_x, ep_y, jx, jy;
        usq_t                                t1h, t1l, t2h, t2l;
        rhs_t                                rhs;
    } c2_t;

    typedef struct packed {
        logic                                ep_hit, den_zero;
        spj_pkg::coord_t                     ep_x, ep_y, jx, jy;
        logic [NUM_W-1:0]                    lhs;
        rhs_t                                rhs;
    } c3_t;

    // overshoot of a crossing parameter beyond [0, den]
    function automatic usq_t overshoot(cross_t n, usq_t d);
        cross_t dn;
        cross_t diff;
        cross_t neg_n;
        begin
            dn    = $signed({1'b0, d});
            diff  = n - dn;
            neg_n = -n;
            if (n < 0)
                overshoot = neg_n[PROD_W-1:0];
            else if (n > dn)
                overshoot = diff[PROD_W-1:0];
            else
                overshoot = '0;
        end
    endfunction

    // start point plus rounded offset, saturated to the coordinate range
    function automatic spj_pkg::coord_t place(spj_pkg::coord_t p, quo_t q,
                                              logic neg, logic ovf);
        logic signed [QUO_W+1:0] qs;
        logic signed [QUO_W+1:0] s;
        begin
            qs = $signed({2'b00, q});
            if (neg)
                qs = -qs;
            s = p + qs;
            if (ovf)
                place = neg ? spj_pkg::COORD_MIN : spj_pkg::COORD_MAX;
            else if (s > spj_pkg::COORD_MAX)
                place = spj_pkg::COORD_MAX;
            else if (s < spj_pkg::COORD_MIN)
                place = spj_pkg::COORD_MIN;
            else
                place = s[COORD_W-1:0];
        end
    endfunction

    spj_pkg::tol_t    tol_reg;
    logic [NST-1:0]   stage_vld_reg;
    logic             adv;

    a1_t a1_reg, a1_next;
    a2_t a2_reg, a2_next;
    a3_t a3_reg, a3_next;
    a4_t a4_reg, a4_next;
    a5_t a5_reg, a5_next;
    a6_t a6_reg, a6_next;
    b_t  a7_reg, a7_next;
    b_t  b_reg [NB];
    c1_t c1_reg, c1_next;
    c2_t c2_reg, c2_next;
    c3_t c3_reg, c3_next;

    logic             hit_reg, hit_next;
    logic             by_ep_reg, by_ep_next;
    spj_pkg::coord_t  jx_reg, jx_next, jy_reg, jy_next;

    // tolerance register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= spj_pkg::TOL_RESET;
        else if (cfg.valid)
            tol_reg <= cfg.data;
    end

    // pipeline advance and stage valid bits
    assign adv          = !stage_vld_reg[NST-1] || out_ch.ready;
    assign in_ch.ready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_vld_reg <= '0;
        else if (adv)
            stage_vld_reg <= {stage_vld_reg[NST-2:0], in_ch.valid};
    end

    // stage 1: differences and endpoint midpoints
    always_comb
    begin
        spj_pkg::coord_t ax [NPAIR];
        spj_pkg::coord_t ay [NPAIR];
        spj_pkg::coord_t bx [NPAIR];
        spj_pkg::coord_t by [NPAIR];
        diff_t sx;
        diff_t sy;
        ax = '{in_ch.first_start_x, in_ch.first_end_x, in_ch.first_start_x, in_ch.first_end_x};
        ay = '{in_ch.first_start_y, in_ch.first_end_y, in_ch.first_start_y, in_ch.first_end_y};
        bx = '{in_ch.second_start_x, in_ch.second_start_x, in_ch.second_end_x,
               in_ch.second_end_x};
        by = '{in_ch.second_start_y, in_ch.second_start_y, in_ch.second_end_y,
               in_ch.second_end_y};
        a1_next.p1x = in_ch.first_start_x;
        a1_next.p1y = in_ch.first_start_y;
        a1_next.d1x = in_ch.first_end_x - in_ch.first_start_x;
        a1_next.d1y = in_ch.first_end_y - in_ch.first_start_y;
        a1_next.d2x = in_ch.second_end_x - in_ch.second_start_x;
        a1_next.d2y = in_ch.second_end_y - in_ch.second_start_y;
        a1_next.rx  = in_ch.second_start_x - in_ch.first_start_x;
        a1_next.ry  = in_ch.second_start_y - in_ch.first_start_y;
        for (int i = 0; i < NPAIR; i++)
        begin
            a1_next.ep_dx[i] = ax[i] - bx[i];
            a1_next.ep_dy[i] = ay[i] - by[i];
            sx = ax[i] + bx[i];
            sy = ay[i] + by[i];
            a1_next.ep_mx[i] = sx[DIFF_W-1:1];
            a1_next.ep_my[i] = sy[DIFF_W-1:1];
        end
    end

    // stage 2: squares and cross products
    always_comb
    begin
        prod_t qx;
        prod_t qy;
        a2_next.p1x   = a1_reg.p1x;
        a2_next.p1y   = a1_reg.p1y;
        a2_next.d1x   = a1_reg.d1x;
        a2_next.d1y   = a1_reg.d1y;
        a2_next.ep_mx = a1_reg.ep_mx;
        a2_next.ep_my = a1_reg.ep_my;
        for (int i = 0; i < NPAIR; i++)
        begin
            qx = $signed(a1_reg.ep_dx[i]) * $signed(a1_reg.ep_dx[i]);
            qy = $signed(a1_reg.ep_dy[i]) * $signed(a1_reg.ep_dy[i]);
            a2_next.ep_sqx[i] = $unsigned(qx);
            a2_next.ep_sqy[i] = $unsigned(qy);
        end
        a2_next.tt    = tol_reg * tol_reg;
        a2_next.den_a = $signed(a1_reg.d1x) * $signed(a1_reg.d2y);
        a2_next.den_b = $signed(a1_reg.d1y) * $signed(a1_reg.d2x);
        a2_next.tn_a  = $signed(a1_reg.rx) * $signed(a1_reg.d2y);
        a2_next.tn_b  = $signed(a1_reg.ry) * $signed(a1_reg.d2x);
        a2_next.un_a  = $signed(a1_reg.rx) * $signed(a1_reg.d1y);
        a2_next.un_b  = $signed(a1_reg.ry) * $signed(a1_reg.d1x);
        qx = $signed(a1_reg.d1x) * $signed(a1_reg.d1x);
        a2_next.l1x = $unsigned(qx);
        qx = $signed(a1_reg.d1y) * $signed(a1_reg.d1y);
        a2_next.l1y = $unsigned(qx);
        qx = $signed(a1_reg.d2x) * $signed(a1_reg.d2x);
        a2_next.l2x = $unsigned(qx);
        qx = $signed(a1_reg.d2y) * $signed(a1_reg.d2y);
        a2_next.l2y = $unsigned(qx);
    end

    // stage 3: endpoint proximity with priority, denominators and lengths squared
    always_comb
    begin
        usq_t s;
        a3_next.p1x    = a2_reg.p1x;
        a3_next.p1y    = a2_reg.p1y;
        a3_next.d1x    = a2_reg.d1x;
        a3_next.d1y    = a2_reg.d1y;
        a3_next.ep_hit = 1'b0;
        a3_next.ep_x   = '0;
        a3_next.ep_y   = '0;
        for (int i = NPAIR - 1; i >= 0; i--)
        begin
            s = a2_reg.ep_sqx[i] + a2_reg.ep_sqy[i];
            if (s <= usq_t'(a2_reg.tt))
            begin
                a3_next.ep_hit = 1'b1;
                a3_next.ep_x   = a2_reg.ep_mx[i];
                a3_next.ep_y   = a2_reg.ep_my[i];
            end
        end
        a3_next.den    = a2_reg.den_a - a2_reg.den_b;
        a3_next.tn     = a2_reg.tn_a - a2_reg.tn_b;
        a3_next.un     = a2_reg.un_a - a2_reg.un_b;
        a3_next.len1sq = a2_reg.l1x + a2_reg.l1y;
        a3_next.len2sq = a2_reg.l2x + a2_reg.l2y;
    end

    // stage 4: make the denominator positive
    always_comb
    begin
        cross_t dneg;
        logic   neg;
        dneg = -a3_reg.den;
        neg  = a3_reg.den < 0;
        a4_next.ep_hit   = a3_reg.ep_hit;
        a4_next.ep_x     = a3_reg.ep_x;
        a4_next.ep_y     = a3_reg.ep_y;
        a4_next.p1x      = a3_reg.p1x;
        a4_next.p1y      = a3_reg.p1y;
        a4_next.d1x      = a3_reg.d1x;
        a4_next.d1y      = a3_reg.d1y;
        a4_next.den_zero = a3_reg.den == 0;
        a4_next.den      = neg ? dneg[PROD_W-1:0] : a3_reg.den[PROD_W-1:0];
        a4_next.tn       = neg ? -a3_reg.tn : a3_reg.tn;
        a4_next.un       = neg ? -a3_reg.un : a3_reg.un;
        a4_next.len1sq   = a3_reg.len1sq;
        a4_next.len2sq   = a3_reg.len2sq;
    end

    // stage 5: overshoots, partial products of the offset numerators, tolerance side
    always_comb
    begin
        a5_next.ep_hit   = a4_reg.ep_hit;
        a5_next.den_zero = a4_reg.den_zero;
        a5_next.ep_x     = a4_reg.ep_x;
        a5_next.ep_y     = a4_reg.ep_y;
        a5_next.p1x      = a4_reg.p1x;
        a5_next.p1y      = a4_reg.p1y;
        a5_next.den      = a4_reg.den;
        a5_next.ot       = overshoot(a4_reg.tn, a4_reg.den);
        a5_next.ou       = overshoot(a4_reg.un, a4_reg.den);
        a5_next.pxh      = $signed(a4_reg.d1x) * $signed(a4_reg.tn[CROSS_W-1:SPLIT]);
        a5_next.pxl      = $signed(a4_reg.d1x) * $signed({1'b0, a4_reg.tn[SPLIT-1:0]});
        a5_next.pyh      = $signed(a4_reg.d1y) * $signed(a4_reg.tn[CROSS_W-1:SPLIT]);
        a5_next.pyl      = $signed(a4_reg.d1y) * $signed({1'b0, a4_reg.tn[SPLIT-1:0]});
        a5_next.rhs      = tol_reg * a4_reg.den;
        a5_next.len1sq   = a4_reg.len1sq;
        a5_next.len2sq   = a4_reg.len2sq;
    end

    // stage 6: join the partial products
    always_comb
    begin
        num_t hx;
        num_t lx;
        num_t hy;
        num_t ly;
        hx = a5_reg.pxh;
        lx = a5_reg.pxl;
        hy = a5_reg.pyh;
        ly = a5_reg.pyl;
        a6_next.ep_hit   = a5_reg.ep_hit;
        a6_next.den_zero = a5_reg.den_zero;
        a6_next.ep_x     = a5_reg.ep_x;
        a6_next.ep_y     = a5_reg.ep_y;
        a6_next.p1x      = a5_reg.p1x;
        a6_next.p1y      = a5_reg.p1y;
        a6_next.den      = a5_reg.den;
        a6_next.ot       = a5_reg.ot;
        a6_next.ou       = a5_reg.ou;
        a6_next.numx     = (hx <<< SPLIT) + lx;
        a6_next.numy     = (hy <<< SPLIT) + ly;
        a6_next.rhs      = a5_reg.rhs;
        a6_next.len1sq   = a5_reg.len1sq;
        a6_next.len2sq   = a5_reg.len2sq;
    end

    // stage 7: rounding dividends 2|num| + den over divisor 2 den
    always_comb
    begin
        logic signed [REM_W-1:0] de;
        logic signed [REM_W-1:0] nx;
        logic signed [REM_W-1:0] ny;
        de = $signed({(REM_W - PROD_W)'(0), a6_reg.den});
        nx = a6_reg.numx;
        ny = a6_reg.numy;
        nx = nx <<< 1;
        ny = ny <<< 1;
        a7_next.ep_hit   = a6_reg.ep_hit;
        a7_next.den_zero = a6_reg.den_zero;
        a7_next.ep_x     = a6_reg.ep_x;
        a7_next.ep_y     = a6_reg.ep_y;
        a7_next.p1x      = a6_reg.p1x;
        a7_next.p1y      = a6_reg.p1y;
        a7_next.ot       = a6_reg.ot;
        a7_next.ou       = a6_reg.ou;
        a7_next.rhs      = a6_reg.rhs;
        a7_next.dd       = {a6_reg.den, 1'b0};
        a7_next.negx     = a6_reg.numx < 0;
        a7_next.negy     = a6_reg.numy < 0;
        a7_next.ovfx     = 1'b0;
        a7_next.ovfy     = 1'b0;
        a7_next.remx     = $unsigned(a7_next.negx ? de - nx : de + nx);
        a7_next.remy     = $unsigned(a7_next.negy ? de - ny : de + ny);
        a7_next.qx       = '0;
        a7_next.qy       = '0;
        a7_next.srem1    = srem_t'(a6_reg.len1sq);
        a7_next.srem2    = srem_t'(a6_reg.len2sq);
        a7_next.root1    = '0;
        a7_next.root2    = '0;
    end

    // stages 8 to 29: one quotient bit per stage, plus a root bit in all but the last
    for (genvar s = 0; s < NB; s++)
    begin : g_step
        localparam int  QB     = NB - 1 - s;
        localparam bit  DO_SRT = s < SRT_STEPS;
        localparam int  K      = DO_SRT ? SRT_STEPS - 1 - s : 0;
        b_t b_in;
        b_t b_next;

        if (s == 0)
        begin : g_head
            assign b_in = a7_reg;
        end
        else
        begin : g_body
            assign b_in = b_reg[s-1];
        end

        always_comb
        begin
            rem_t  dsh;
            srem_t tr1;
            srem_t tr2;
            b_next = b_in;
            dsh    = rem_t'(b_in.dd) << QB;
            if (s == 0)
            begin
                b_next.ovfx = b_in.remx >= (rem_t'(b_in.dd) << NB);
                b_next.ovfy = b_in.remy >= (rem_t'(b_in.dd) << NB);
            end
            if (b_in.remx >= dsh)
            begin
                b_next.remx     = b_in.remx - dsh;
                b_next.qx[QB]   = 1'b1;
            end
            if (b_in.remy >= dsh)
            begin
                b_next.remy     = b_in.remy - dsh;
                b_next.qy[QB]   = 1'b1;
            end
            tr1 = (srem_t'(b_in.root1) << (K + 1)) + (srem_t'(1) << (2 * K));
            tr2 = (srem_t'(b_in.root2) << (K + 1)) + (srem_t'(1) << (2 * K));
            if (DO_SRT && b_in.srem1 >= tr1)
            begin
                b_next.srem1 = b_in.srem1 - tr1;
                b_next.root1 = b_in.root1 | (len_t'(1) << K);
            end
            if (DO_SRT && b_in.srem2 >= tr2)
            begin
                b_next.srem2 = b_in.srem2 - tr2;
                b_next.root2 = b_in.root2 | (len_t'(1) << K);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                b_reg[s] <= b_next;
        end
    end

    // stage 30: rounded lengths and saturated crossing point
    always_comb
    begin
        b_t bl;
        bl = b_reg[NB-1];
        c1_next.ep_hit   = bl.ep_hit;
        c1_next.den_zero = bl.den_zero;
        c1_next.ep_x     = bl.ep_x;
        c1_next.ep_y     = bl.ep_y;
        c1_next.jx       = place(bl.p1x, bl.qx, bl.negx, bl.ovfx);
        c1_next.jy       = place(bl.p1y, bl.qy, bl.negy, bl.ovfy);
        c1_next.ot       = bl.ot;
        c1_next.ou       = bl.ou;
        c1_next.len1     = bl.root1 + len_t'(bl.srem1 > srem_t'(bl.root1));
        c1_next.len2     = bl.root2 + len_t'(bl.srem2 > srem_t'(bl.root2));
        c1_next.rhs      = bl.rhs;
    end

    // stage 31: overshoot times length, split in halves
    always_comb
    begin
        c2_next.ep_hit   = c1_reg.ep_hit;
        c2_next.den_zero = c1_reg.den_zero;
        c2_next.ep_x     = c1_reg.ep_x;
        c2_next.ep_y     = c1_reg.ep_y;
        c2_next.jx       = c1_reg.jx;
        c2_next.jy       = c1_reg.jy;
        c2_next.t1h      = c1_reg.ot[PROD_W-1:SPLIT] * c1_reg.len1;
        c2_next.t1l      = c1_reg.ot[SPLIT-1:0] * c1_reg.len1;
        c2_next.t2h      = c1_reg.ou[PROD_W-1:SPLIT] * c1_reg.len2;
        c2_next.t2l      = c1_reg.ou[SPLIT-1:0] * c1_reg.len2;
        c2_next.rhs      = c1_reg.rhs;
    end

    // stage 32: summed overshoot
    always_comb
    begin
        c3_next.ep_hit   = c2_reg.ep_hit;
        c3_next.den_zero = c2_reg.den_zero;
        c3_next.ep_x     = c2_reg.ep_x;
        c3_next.ep_y     = c2_reg.ep_y;
        c3_next.jx       = c2_reg.jx;
        c3_next.jy       = c2_reg.jy;
        c3_next.lhs      = (NUM_W'(c2_reg.t1h) << SPLIT) + NUM_W'(c2_reg.t1l)
                         + (NUM_W'(c2_reg.t2h) << SPLIT) + NUM_W'(c2_reg.t2l);
        c3_next.rhs      = c2_reg.rhs;
    end

    // stage 33: result select into the output register
    always_comb
    begin
        hit_next   = 1'b0;
        by_ep_next = 1'b0;
        jx_next    = '0;
        jy_next    = '0;
        if (c3_reg.ep_hit)
        begin
            hit_next   = 1'b1;
            by_ep_next = 1'b1;
            jx_next    = c3_reg.ep_x;
            jy_next    = c3_reg.ep_y;
        end
        else if (!c3_reg.den_zero && c3_reg.lhs <= NUM_W'(c3_reg.rhs))
        begin
            hit_next = 1'b1;
            jx_next  = c3_reg.jx;
            jy_next  = c3_reg.jy;
        end
    end

    // payload registers of the fixed stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg    <= a1_next;
            a2_reg    <= a2_next;
            a3_reg    <= a3_next;
            a4_reg    <= a4_next;
            a5_reg    <= a5_next;
            a6_reg    <= a6_next;
            a7_reg    <= a7_next;
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            c3_reg    <= c3_next;
            hit_reg   <= hit_next;
            by_ep_reg <= by_ep_next;
            jx_reg    <= jx_next;
            jy_reg    <= jy_next;
        end
    end

    assign out_ch.valid       = stage_vld_reg[NST-1];
    assign out_ch.hit         = hit_reg;
    assign out_ch.by_endpoint = by_ep_reg;
    assign out_ch.junction_x  = jx_reg;
    assign out_ch.junction_y  = jy_reg;

    // an endpoint junction is always a hit
    a_ep_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (!out_ch.by_endpoint || out_ch.hit))
        else $error("endpoint result without hit");

    // a miss carries a zero junction
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.hit) |-> (out_ch.junction_x == 0 && out_ch.junction_y == 0))
        else $error("miss with non-zero junction");

    // an accepted request enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> stage_vld_reg[0])
        else $error("accepted request lost at pipeline entry");

    // a stalled result stays put
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(jx_reg) && $stable(hit_reg)))
        else $error("stalled result changed");

endmodule

// ===== tb/tb_segment_pair_junction_unit.sv =====
// ----------------------------------------------------------------------------
// tb_segment_pair_junction_unit: self-checking bench of the junction unit
// Drives segment pair requests and tolerance writes over valid/ready channels
// with random idling on both sides. Each request's junction is predicted in
// exact wide integer arithmetic and compared in order with the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct {
    spj_pkg::coord_t p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
} seg_pair_t;

typedef struct {
    logic            hit;
    spj_pkg::coord_t jx;
    spj_pkg::coord_t jy;
    logic            by_ep;
} junction_t;

typedef logic signed [127:0] wide_t;

// predicts junctions and checks them in request order
class junction_scoreboard;
    junction_t     expected_junctions[$];
    spj_pkg::tol_t tolerance;
    int            mismatches;
    int            results_seen;
    int            hits_by_endpoint;
    int            hits_by_crossing;

    function new();
        tolerance  = spj_pkg::TOL_RESET;
        mismatches = 0;
        results_seen = 0;
        hits_by_endpoint = 0;
        hits_by_crossing = 0;
    endfunction

    // rounded integer square root
    function longint unsigned root_round(longint unsigned v);
        longint unsigned rem, root, b;
        rem = v;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        if (v - root * root > root)
            root = root + 1;
        return root;
    endfunction

    // nearest, ties away from zero, den positive
    function wide_t quot_round(wide_t num, wide_t den);
        wide_t m, q;
        m = (num < 0) ? -num : num;
        q = (2 * m + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function wide_t beyond_end(wide_t n, wide_t den);
        if (n < 0)
            return -n;
        if (n > den)
            return n - den;
        return 0;
    endfunction

    function spj_pkg::coord_t clamp_coord(wide_t v);
        if (v > 524287)
            return spj_pkg::COORD_MAX;
        if (v < -524288)
            return spj_pkg::COORD_MIN;
        return spj_pkg::coord_t'(v);
    endfunction

    function junction_t predict_junction(seg_pair_t s);
        junction_t j;
        wide_t ax[4], ay[4], bx[4], by[4];
        wide_t t, dx, dy, d1x, d1y, d2x, d2y, rx, ry, den, tn, un, lhs, rhs;
        longint unsigned len1, len2;
        j = '{1'b0, '0, '0, 1'b0};
        t = wide_t'(tolerance);
        // endpoint pairs in priority order
        ax = '{wide_t'(s.p1x), wide_t'(s.p2x), wide_t'(s.p1x), wide_t'(s.p2x)};
        ay = '{wide_t'(s.p1y), wide_t'(s.p2y), wide_t'(s.p1y), wide_t'(s.p2y)};
        bx = '{wide_t'(s.q1x), wide_t'(s.q1x), wide_t'(s.q2x), wide_t'(s.q2x)};
        by = '{wide_t'(s.q1y), wide_t'(s.q1y), wide_t'(s.q2y), wide_t'(s.q2y)};
        for (int k = 0; k < 4; k++)
        begin
            dx = ax[k] - bx[k];
            dy = ay[k] - by[k];
            if (dx * dx + dy * dy <= t * t)
            begin
                j.hit = 1'b1;
                j.by_ep = 1'b1;
                j.jx = spj_pkg::coord_t'((ax[k] + bx[k]) >>> 1);
                j.jy = spj_pkg::coord_t'((ay[k] + by[k]) >>> 1);
                return j;
            end
        end
        // line crossing
        d1x = wide_t'(s.p2x) - wide_t'(s.p1x);
        d1y = wide_t'(s.p2y) - wide_t'(s.p1y);
        d2x = wide_t'(s.q2x) - wide_t'(s.q1x);
        d2y = wide_t'(s.q2y) - wide_t'(s.q1y);
        rx  = wide_t'(s.q1x) - wide_t'(s.p1x);
        ry  = wide_t'(s.q1y) - wide_t'(s.p1y);
        den = d1x * d2y - d1y * d2x;
        if (den == 0)
            return j;
        tn = rx * d2y - ry * d2x;
        un = rx * d1y - ry * d1x;
        if (den < 0)
        begin
            den = -den;
            tn = -tn;
            un = -un;
        end
        len1 = root_round(64'(d1x * d1x + d1y * d1y));
        len2 = root_round(64'(d2x * d2x + d2y * d2y));
        lhs = beyond_end(tn, den) * wide_t'(len1) + beyond_end(un, den) * wide_t'(len2);
        rhs = t * den;
        if (lhs > rhs)
            return j;
        j.hit = 1'b1;
        j.jx = clamp_coord(wide_t'(s.p1x) + quot_round(d1x * tn, den));
        j.jy = clamp_coord(wide_t'(s.p1y) + quot_round(d1y * tn, den));
        return j;
    endfunction

    function void note_request(seg_pair_t s);
        expected_junctions = {expected_junctions, predict_junction(s)};
    endfunction

    function void check_result(junction_t got);
        junction_t want;
        results_seen++;
        if (expected_junctions.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with no request pending: hit=%0b x=%0d y=%0d ep=%0b",
                         got.hit, got.jx, got.jy, got.by_ep);
            return;
        end
        want = expected_junctions.pop_front();
        if (want.hit && want.by_ep)
            hits_by_endpoint++;
        else if (want.hit)
            hits_by_crossing++;
        if (got.hit !== want.hit || got.jx !== want.jx || got.jy !== want.jy
            || got.by_ep !== want.by_ep)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d exp hit=%0b x=%0d y=%0d ep=%0b",
                         results_seen, want.hit, want.jx, want.jy, want.by_ep,
                         " got hit=%0b x=%0d y=%0d ep=%0b",
                         got.hit, got.jx, got.jy, got.by_ep);
        end
    endfunction
endclass

module tb_segment_pair_junction_unit;

    localparam int LATENCY     = 33;
    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;
    int   hold_requests;
    int   holds_started;
    int   requests_sent;

    junction_scoreboard sb;

    spj_in_if  in_ch ();
    spj_out_if out_ch ();
    spj_cfg_if cfg ();

    segment_pair_junction_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // monitor of accepted requests, results and tolerance writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_request('{in_ch.first_start_x, in_ch.first_start_y,
                                  in_ch.first_end_x, in_ch.first_end_y,
                                  in_ch.second_start_x, in_ch.second_start_y,
                                  in_ch.second_end_x, in_ch.second_end_y});
            if (out_ch.valid && out_ch.ready)
                sb.check_result('{out_ch.hit, out_ch.junction_x, out_ch.junction_y,
                                  out_ch.by_endpoint});
            if (cfg.valid && cfg.ready)
                sb.tolerance = cfg.data;
        end
    end

    // receiver: random stalls plus the long hold-off
    always @(negedge clk)
    begin
        if (hold_requests != holds_started)
        begin
            holds_started = hold_requests;
            hold_off = 150;
        end
        if (hold_off > 0)
        begin
            out_ch.ready = 1'b0;
            hold_off = hold_off - 1;
        end
        else
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_pair(seg_pair_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid          = 1'b1;
        in_ch.first_start_x  = s.p1x;
        in_ch.first_start_y  = s.p1y;
        in_ch.first_end_x    = s.p2x;
        in_ch.first_end_y    = s.p2y;
        in_ch.second_start_x = s.q1x;
        in_ch.second_start_y = s.q1y;
        in_ch.second_end_x   = s.q2x;
        in_ch.second_end_y   = s.q2y;
        do
            @(posedge clk);
        while (!in_ch.ready);
        requests_sent++;
        @(negedge clk);
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        in_ch.valid = 1'b0;
        while (sb.expected_junctions.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic write_tolerance(spj_pkg::tol_t v);
        cfg.valid = 1'b1;
        cfg.data  = v;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    function automatic spj_pkg::coord_t near(spj_pkg::coord_t c, int spread);
        return spj_pkg::coord_t'(int'(c) + $signed($urandom_range(2 * spread)) - spread);
    endfunction

    // random pair shaped to reach endpoint, crossing, parallel and far cases
    function automatic seg_pair_t random_pair();
        seg_pair_t s;
        int kind, span;
        spj_pkg::coord_t cx, cy;
        kind = $urandom_range(99);
        span = ($urandom_range(9) == 0) ? 200000 : 1 << $urandom_range(4, 12);
        cx = spj_pkg::coord_t'($urandom);
        cy = spj_pkg::coord_t'($urandom);
        s.p1x = near(cx, span);
        s.p1y = near(cy, span);
        s.p2x = near(cx, span);
        s.p2y = near(cy, span);
        s.q1x = near(cx, span);
        s.q1y = near(cy, span);
        s.q2x = near(cx, span);
        s.q2y = near(cy, span);
        if (kind < 20)
        begin
            // full-range noise
            s = '{spj_pkg::coord_t'($urandom), spj_pkg::coord_t'($urandom),
                  spj_pkg::coord_t'($urandom), spj_pkg::coord_t'($urandom),
                  spj_pkg::coord_t'($urandom), spj_pkg::coord_t'($urandom),
                  spj_pkg::coord_t'($urandom), spj_pkg::coord_t'($urandom)};
        end
        else if (kind < 40)
        begin
            // one endpoint of the second segment close to one of the first
            case ($urandom_range(3))
                0:
                begin
                    s.q1x = near(s.p1x, 40);
                    s.q1y = near(s.p1y, 40);
                end
                1:
                begin
                    s.q1x = near(s.p2x, 40);
                    s.q1y = near(s.p2y, 40);
                end
                2:
                begin
                    s.q2x = near(s.p1x, 40);
                    s.q2y = near(s.p1y, 40);
                end
                default:
                begin
                    s.q2x = near(s.p2x, 40);
                    s.q2y = near(s.p2y, 40);
                end
            endcase
        end
        else if (kind < 50)
        begin
            // parallel copy, possibly collinear
            s.q2x = spj_pkg::coord_t'(s.q1x + s.p2x - s.p1x);
            s.q2y = spj_pkg::coord_t'(s.q1y + s.p2y - s.p1y);
        end
        else if (kind < 55)
        begin
            // degenerate point segment
            s.q2x = s.q1x;
            s.q2y = s.q1y;
        end
        return s;
    endfunction

    initial
    begin
        seg_pair_t     directed[$];
        spj_pkg::tol_t tol_plan[5];
        int            idle_plan[4][2];
        int            n;

        sb = new();
        hold_requests = 0;
        requests_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.first_start_x = '0;
        in_ch.first_start_y = '0;
        in_ch.first_end_x = '0;
        in_ch.first_end_y = '0;
        in_ch.second_start_x = '0;
        in_ch.second_start_y = '0;
        in_ch.second_end_x = '0;
        in_ch.second_end_y = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed cases at the reset tolerance
        directed = '{
            '{0, 0, 160, 0, 0, 8, 0, 160},                // start-start close
            '{0, 0, 160, 0, 168, 0, 300, 300},            // end-start close
            '{0, 0, 160, 0, 500, 500, 8, 8},              // start-end close
            '{0, 0, 160, 0, 500, 500, 164, 4},            // end-end close
            '{0, 0, 16, 0, 16, 16, 0, 0},                 // three pairs close, first wins
            '{0, 0, 160, 160, 0, 160, 160, 0},            // plain crossing
            '{0, 0, 160, 0, 200, -100, 200, 100},         // overshoot too long
            '{0, 0, 160, 0, 170, -100, 170, 100},         // overshoot within tolerance
            '{0, 0, 160, 0, 0, 100, 160, 100},            // parallel
            '{0, 0, 160, 0, 320, 0, 480, 0},              // collinear apart
            '{0, 0, 0, 0, 500, 500, 500, 500},            // both degenerate
            '{0, 0, 3, 0, 100, 5, 100, 7},                // tiny segments, crossing far out
            '{spj_pkg::COORD_MAX, spj_pkg::COORD_MAX, spj_pkg::COORD_MAX,
              spj_pkg::COORD_MAX, spj_pkg::COORD_MAX, spj_pkg::COORD_MAX,
              spj_pkg::COORD_MAX, spj_pkg::COORD_MAX},
            '{spj_pkg::COORD_MIN, spj_pkg::COORD_MIN, spj_pkg::COORD_MIN,
              spj_pkg::COORD_MIN, spj_pkg::COORD_MIN, spj_pkg::COORD_MIN,
              spj_pkg::COORD_MIN, spj_pkg::COORD_MIN},
            '{spj_pkg::COORD_MIN, spj_pkg::COORD_MIN, spj_pkg::COORD_MAX,
              spj_pkg::COORD_MAX, spj_pkg::COORD_MIN, spj_pkg::COORD_MAX,
              spj_pkg::COORD_MAX, spj_pkg::COORD_MIN},
            '{spj_pkg::COORD_MAX, 0, spj_pkg::coord_t'(spj_pkg::COORD_MAX - 1), 1,
              spj_pkg::COORD_MIN, 5, spj_pkg::coord_t'(spj_pkg::COORD_MIN + 1), 5},
            '{spj_pkg::coord_t'(spj_pkg::COORD_MAX - 20), 0, spj_pkg::COORD_MAX, 1,
              spj_pkg::coord_t'(spj_pkg::COORD_MAX - 20), 10, spj_pkg::COORD_MAX, 9},
            '{-1, -1, 100, 0, -2, 0, 100, 300},           // negative midpoint rounding
            '{-3, 5, 400, 7, 14, 5, 300, 900},            // just outside one pixel
            '{0, 0, 1000, 1, 0, 1, 1000, 0}                // shallow crossing
        };
        foreach (directed[k])
            send_pair(directed[k]);
        drain();

        tol_plan  = '{spj_pkg::tol_t'(0), spj_pkg::tol_t'(16383), spj_pkg::tol_t'(48),
                      spj_pkg::tol_t'($urandom_range(16383)),
                      spj_pkg::tol_t'(spj_pkg::TOL_RESET)};
        idle_plan = '{'{0, 0}, '{77, 0}, '{0, 77}, '{22, 22}};

        for (int ph = 0; ph < 5; ph++)
        begin
            write_tolerance(tol_plan[ph]);
            send_idle_pct  = idle_plan[ph % 4][0];
            recv_stall_pct = idle_plan[ph % 4][1];
            n = (ph == 4) ? 200 : 410;
            for (int k = 0; k < n; k++)
            begin
                // long receiver hold-off while requests keep coming
                if (ph == 0 && k == 50)
                    hold_requests = hold_requests + 1;
                send_pair(random_pair());
            end
            drain();
        end

        repeat (LATENCY + 8) @(negedge clk);
        $display("Covered %0d requests over six tolerance settings and four idling patterns",
                 requests_sent);
        $display("Hits by endpoint %0d, by crossing %0d, results %0d, mismatches %0d",
                 sb.hits_by_endpoint, sb.hits_by_crossing, sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_junctions.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
